### hw/rtl/gamma_pwm_shift_frame_defines.svh
// assertion macros for the led pwm frame driver
`ifndef GAMMA_PWM_SHIFT_FRAME_DEFINES_SVH
`define GAMMA_PWM_SHIFT_FRAME_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define GPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gps implication check failed");
// next-cycle implication, checked outside reset
`define GPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gps next-cycle check failed");
`else
`define GPS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/gps_pkg.sv
// shared types, codes and gamma table for the led pwm frame driver
`default_nettype none
package gps_pkg;

  localparam int IDX_W = 5;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] led_index;
    logic [7:0]       brightness;
  } req_t;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic       last_byte;
  } rsp_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  localparam logic [7:0] GAMMA_LUT [256] = '{
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,
    8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd4,   8'd5,   8'd5,
    8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,   8'd6,   8'd7,
    8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd9,   8'd9,   8'd9,
    8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd11,  8'd12,  8'd12,
    8'd13,  8'd13,  8'd13,  8'd14,  8'd14,  8'd15,  8'd15,  8'd16,
    8'd16,  8'd17,  8'd17,  8'd18,  8'd18,  8'd19,  8'd19,  8'd20,
    8'd20,  8'd21,  8'd21,  8'd22,  8'd22,  8'd23,  8'd24,  8'd24,
    8'd25,  8'd25,  8'd26,  8'd27,  8'd27,  8'd28,  8'd29,  8'd29,
    8'd30,  8'd31,  8'd31,  8'd32,  8'd33,  8'd34,  8'd34,  8'd35,
    8'd36,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,  8'd41,  8'd42,
    8'd42,  8'd43,  8'd44,  8'd45,  8'd46,  8'd47,  8'd48,  8'd49,
    8'd50,  8'd51,  8'd52,  8'd53,  8'd54,  8'd55,  8'd56,  8'd57,
    8'd58,  8'd59,  8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,
    8'd66,  8'd68,  8'd69,  8'd70,  8'd71,  8'd72,  8'd73,  8'd75,
    8'd76,  8'd77,  8'd78,  8'd80,  8'd81,  8'd82,  8'd84,  8'd85,
    8'd86,  8'd88,  8'd89,  8'd90,  8'd92,  8'd93,  8'd94,  8'd96,
    8'd97,  8'd99,  8'd100, 8'd102, 8'd103, 8'd105, 8'd106, 8'd108,
    8'd109, 8'd111, 8'd112, 8'd114, 8'd115, 8'd117, 8'd119, 8'd120,
    8'd122, 8'd124, 8'd125, 8'd127, 8'd129, 8'd130, 8'd132, 8'd134,
    8'd136, 8'd137, 8'd139, 8'd141, 8'd143, 8'd145, 8'd146, 8'd148,
    8'd150, 8'd152, 8'd154, 8'd156, 8'd158, 8'd160, 8'd162, 8'd164,
    8'd166, 8'd168, 8'd170, 8'd172, 8'd174, 8'd176, 8'd178, 8'd180,
    8'd182, 8'd184, 8'd186, 8'd188, 8'd191, 8'd193, 8'd195, 8'd197,
    8'd199, 8'd202, 8'd204, 8'd206, 8'd209, 8'd211, 8'd213, 8'd215,
    8'd218, 8'd220, 8'd223, 8'd225, 8'd227, 8'd230, 8'd232, 8'd235,
    8'd237, 8'd240, 8'd242, 8'd245, 8'd247, 8'd250, 8'd252, 8'd255
  };

endpackage
`default_nettype wire

### hw/rtl/gamma_pwm_shift_frame.sv
// top level of the gamma corrected pwm led frame driver
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------------------
//   request | req_valid | req_stall | req : action, led_index, brightness
//   result  | rsp_valid | rsp_stall | rsp : shift_byte, last_byte
//
// a write request gives no result
// a tick request yields (NUM_LEDS+7)/8 result bytes, one per cycle while rsp_stall
//   is low, through the single back-end byte port
// the front keeps accepting while the two-entry frame queue has room
// rst clears the whole brightness store and the phase
// a stalled result holds in the output register; the queue absorbs two frames
`default_nettype none
`include "gamma_pwm_shift_frame_defines.svh"
module gamma_pwm_shift_frame #(
  parameter int NUM_LEDS    = 24,
  parameter int PHASE_STEPS = 128
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire gps_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output gps_pkg::rsp_t      rsp
);

  localparam int NB = (NUM_LEDS + 7) / 8;
  localparam int FW = NB * 8;

  // frame bits from front to queue, and queue head to back
  logic [FW-1:0]       push_frame;
  logic [NB-1:0][7:0]  head;
  logic                q_push;
  logic                q_pop;
  gps_pkg::q_stat_t    q_stat;

  // front: stores brightness writes, turns a tick into a frame of led bits
  gps_front #(
    .NUM_LEDS    (NUM_LEDS),
    .PHASE_STEPS (PHASE_STEPS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_frame   (push_frame)
  );

  // short queue decouples tick acceptance from byte drain
  gps_queue #(
    .WIDTH (FW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_frame),
    .pop       (q_pop),
    .head      (head),
    .stat      (q_stat)
  );

  // back: emits the frame bytes through the output register
  gps_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // never push into a full queue
  `GPS_ASSERT_IMPL(a_no_overflow, clk, rst, q_push, !q_stat.full)
  // a pushed frame is visible to the back next cycle
  `GPS_ASSERT_NEXT(a_push_seen, clk, rst, q_push, q_stat.not_empty)
  // a result only starts from a queued frame
  `GPS_ASSERT_IMPL(a_rsp_from_queue, clk, rst, $rose(rsp_valid), $past(q_stat.not_empty))
  // pop only when a frame is there
  `GPS_ASSERT_IMPL(a_no_underflow, clk, rst, q_pop, q_stat.not_empty)

endmodule
`default_nettype wire

### hw/rtl/gps_front.sv
// front end: brightness store, pwm phase and per-tick led bit frame
`default_nettype none
module gps_front #(
  parameter int NUM_LEDS    = 24,
  parameter int PHASE_STEPS = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire gps_pkg::req_t        req,
  input  wire gps_pkg::q_stat_t     q_stat,
  output logic                      q_push,
  output logic [((NUM_LEDS+7)/8)*8-1:0] q_frame
);

  localparam int NB = (NUM_LEDS + 7) / 8;
  localparam int FW = NB * 8;
  localparam int LW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int PW = (PHASE_STEPS > 1) ? $clog2(PHASE_STEPS) : 1;

  logic [7:0]    store [NUM_LEDS];
  logic [PW-1:0] phase;
  logic          accept;
  logic          wr_en;
  logic [LW-1:0] wr_idx;

  assign req_stall = q_stat.full;
  assign accept    = req_valid && !req_stall;
  assign q_push    = accept && (req.action == gps_pkg::ACT_TICK);
  assign wr_en     = accept && (req.action == gps_pkg::ACT_WRITE) &&
                     (32'(req.led_index) < 32'(NUM_LEDS));
  assign wr_idx    = LW'(req.led_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        store[i] <= 8'd0;
      end
    end else if (wr_en) begin
      store[wr_idx] <= req.brightness;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (q_push) begin
      if (phase == PW'(PHASE_STEPS - 1)) begin
        phase <= '0;
      end else begin
        phase <= phase + 1'b1;
      end
    end
  end

  // led on while phase is below its corrected level; pad bits stay off
  for (genvar g = 0; g < FW; g++) begin : g_bit
    if (g < NUM_LEDS) begin : g_led
      assign q_frame[g] = 9'(phase) < 9'(gps_pkg::GAMMA_LUT[store[g]]);
    end else begin : g_pad
      assign q_frame[g] = 1'b0;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/gps_queue.sv
// two-entry frame queue between front and back
`default_nettype none
module gps_queue #(
  parameter int WIDTH = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output gps_pkg::q_stat_t      stat
);

  logic [WIDTH-1:0] mem [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;

  assign stat.full      = (cnt == 2'd2);
  assign stat.not_empty = (cnt != 2'd0);
  assign head           = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      unique case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/gps_back.sv
// back end: splits a frame into shift bytes, highest group first
`default_nettype none
module gps_back #(
  parameter int NUM_LEDS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [(NUM_LEDS+7)/8-1:0][7:0] head,
  input  wire gps_pkg::q_stat_t              q_stat,
  output logic                               q_pop,
  output logic                               rsp_valid,
  input  wire logic                          rsp_stall,
  output gps_pkg::rsp_t                      rsp
);

  localparam int NB = (NUM_LEDS + 7) / 8;
  localparam int GW = (NB > 1) ? $clog2(NB) : 1;

  logic [GW-1:0] grp;
  logic          load;
  logic          last;

  assign load  = q_stat.not_empty && (!rsp_valid || !rsp_stall);
  assign last  = (grp == '0);
  assign q_pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      grp       <= GW'(NB - 1);
    end else if (load) begin
      rsp_valid <= 1'b1;
      if (last) begin
        grp <= GW'(NB - 1);
      end else begin
        grp <= grp - 1'b1;
      end
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.shift_byte <= head[grp];
      rsp.last_byte  <= last;
    end
  end

endmodule
`default_nettype wire
